FILE: sv/sipf_pkg.sv
// Shared types and constants for the source IP / source port packet filter.
// No dependencies; used by source_ip_port_packet_filter.

package sipf_pkg;

  // Input beat kinds carried on s_axis_tuser
  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_IP_WR   = 2'd1,
    CMD_PORT_WR = 2'd2
  } cmd_e;

  // Verdict reasons
  typedef enum logic [1:0] {
    REASON_CLEAN    = 2'd0,
    REASON_NOT_IP   = 2'd1,
    REASON_BLK_IP   = 2'd2,
    REASON_BLK_PORT = 2'd3
  } reason_e;

  // One verdict as it leaves the block
  typedef struct packed {
    logic [15:0] src_port;
    logic [31:0] src_ip;
    reason_e     reason;
    logic        drop;
  } verdict_t;

  // Header field constants
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'h06;
  localparam logic [7:0]  PROTO_UDP  = 8'h11;

  // Byte offsets within the frame (0 based)
  localparam logic [5:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [5:0] POS_PROTO     = 6'd23;
  localparam logic [5:0] POS_SIP_FIRST = 6'd26;
  localparam logic [5:0] POS_SIP_LAST  = 6'd29;
  localparam logic [5:0] POS_SPORT_HI  = 6'd34;
  localparam logic [5:0] POS_SPORT_LO  = 6'd35;
  localparam logic [5:0] POS_MAX       = 6'd63;

  // Position of the last byte for the minimum lengths (length - 1)
  localparam logic [5:0] POS_MIN_IP  = 6'd33;
  localparam logic [5:0] POS_MIN_TCP = 6'd53;
  localparam logic [5:0] POS_MIN_UDP = 6'd41;

endpackage

FILE: sv/source_ip_port_packet_filter.sv
// Top level of the source IP / source port packet filter.
// Depends on sipf_pkg and sipf_ram.
//
// Usage
//   s_axis carries one beat per item. tuser selects the kind: a frame byte, a
//   write to the blocked-IP table or a write to the blocked-port table. Frame
//   bytes come in wire order with tlast on the final byte of the frame.
//   m_axis gives one verdict beat for each frame, in the cycle after its last
//   byte is taken; table writes and other frame bytes give nothing.
// Throughput
//   One beat per cycle while no last byte is held off. The tables sit in RAMs
//   and are swept one entry per cycle: the IP sweep starts after frame byte 30
//   and the port sweep starts after byte 36. A last byte is held off until
//   running sweeps are done, so with 16 entries frames of 54 bytes or more
//   never wait at full rate. Table writes are taken at any time and update the
//   pending match at once when the key is known.
// Reset
//   Both tables come up empty (valid flags cleared), frame state zeroed.
// Back-pressure
//   The verdict waits in an output register; bytes and writes keep flowing
//   while it waits, and only the next frame's last byte is held off.

module source_ip_port_packet_filter #(
  parameter int IP_ENTRIES   = 16,
  parameter int PORT_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: data_byte[7:0], entry_index[11:8], entry_value[43:12],
  //        entry_valid[44], zero [47:45]
  input  logic [47:0] s_axis_tdata,
  // tuser: command[1:0]
  input  logic [1:0]  s_axis_tuser,
  // tlast: last_byte
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: drop[0], verdict_reason[2:1], seen_source_ip[34:3],
  //        seen_source_port[50:35], zero [55:51]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam int IP_AW   = (IP_ENTRIES > 1) ? $clog2(IP_ENTRIES) : 1;
  localparam int PORT_AW = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;

  // Input beat unpacking
  logic [7:0]  in_byte;
  logic [3:0]  in_index;
  logic [31:0] in_value;
  logic        in_valid_bit;
  logic        in_acc;
  logic        frame_beat;
  logic        ip_wr;
  logic        port_wr;
  logic        verdict_req;

  assign in_byte      = s_axis_tdata[7:0];
  assign in_index     = s_axis_tdata[11:8];
  assign in_value     = s_axis_tdata[43:12];
  assign in_valid_bit = s_axis_tdata[44];
  assign in_acc       = s_axis_tvalid & s_axis_tready;

  // Decode of the beat kind
  always_comb begin
    frame_beat = 1'b0;
    ip_wr      = 1'b0;
    port_wr    = 1'b0;
    case (s_axis_tuser)
      sipf_pkg::CMD_FRAME:   frame_beat = 1'b1;
      sipf_pkg::CMD_IP_WR:   ip_wr      = 32'(in_index) < 32'(IP_ENTRIES);
      sipf_pkg::CMD_PORT_WR: port_wr    = 32'(in_index) < 32'(PORT_ENTRIES);
      default: ;
    endcase
  end

  assign verdict_req = frame_beat & s_axis_tlast;

  logic [IP_AW-1:0]   ip_widx;
  logic [PORT_AW-1:0] port_widx;
  assign ip_widx   = IP_AW'(in_index);
  assign port_widx = PORT_AW'(in_index);

  // Frame capture registers
  logic [5:0]  pos_q, pos_d;
  logic [15:0] etype_q, etype_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] sip_q, sip_d;
  logic [15:0] sport_q, sport_d;

  // IP table: valid flags, sweep control and per-entry match
  logic [IP_ENTRIES-1:0] ip_vld_q, ip_vld_d;
  logic [IP_ENTRIES-1:0] ip_hit_q, ip_hit_d;
  logic                  ip_arm_q, ip_arm_d;
  logic                  ip_act_q, ip_act_d;
  logic [IP_AW-1:0]      ip_idx_q, ip_idx_d;
  logic                  ip_pend_q, ip_pend_d;
  logic [IP_AW-1:0]      ip_ridx_q, ip_ridx_d;
  logic                  ip_skip_q, ip_skip_d;
  logic [31:0]           ip_rdata;

  // Port table, same arrangement
  logic [PORT_ENTRIES-1:0] pt_vld_q, pt_vld_d;
  logic [PORT_ENTRIES-1:0] pt_hit_q, pt_hit_d;
  logic                    pt_arm_q, pt_arm_d;
  logic                    pt_act_q, pt_act_d;
  logic [PORT_AW-1:0]      pt_idx_q, pt_idx_d;
  logic                    pt_pend_q, pt_pend_d;
  logic [PORT_AW-1:0]      pt_ridx_q, pt_ridx_d;
  logic                    pt_skip_q, pt_skip_d;
  logic [15:0]             pt_rdata;

  logic sweep_busy;
  assign sweep_busy = ip_act_q | ip_pend_q | pt_act_q | pt_pend_q;

  // Output register
  logic                m_valid_q, m_valid_d;
  sipf_pkg::verdict_t  m_data_q, m_data_d;
  sipf_pkg::verdict_t  verdict;

  // Hold the last byte while a sweep runs or the verdict slot is blocked
  assign s_axis_tready = !(verdict_req && (sweep_busy || (m_valid_q && !m_axis_tready)));

  // Table RAMs: written by commands, read by the sweeps
  sipf_ram #(
    .WIDTH (32),
    .DEPTH (IP_ENTRIES)
  ) u_ip_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc & ip_wr),
    .waddr_i (ip_widx),
    .wdata_i (in_value),
    .re_i    (ip_act_q),
    .raddr_i (ip_idx_q),
    .rdata_o (ip_rdata)
  );

  sipf_ram #(
    .WIDTH (16),
    .DEPTH (PORT_ENTRIES)
  ) u_port_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc & port_wr),
    .waddr_i (port_widx),
    .wdata_i (in_value[15:0]),
    .re_i    (pt_act_q),
    .raddr_i (pt_idx_q),
    .rdata_o (pt_rdata)
  );

  // Verdict from the captured state and the match vectors
  always_comb begin
    verdict          = '0;
    verdict.reason   = sipf_pkg::REASON_CLEAN;
    if (pos_q < sipf_pkg::POS_MIN_IP || etype_q != sipf_pkg::ETYPE_IPV4) begin
      verdict.reason = sipf_pkg::REASON_NOT_IP;
    end else begin
      verdict.src_ip = sip_q;
      if (|ip_hit_q) begin
        verdict.reason = sipf_pkg::REASON_BLK_IP;
      end else if (proto_q == sipf_pkg::PROTO_TCP || proto_q == sipf_pkg::PROTO_UDP) begin
        if ((proto_q == sipf_pkg::PROTO_TCP && pos_q < sipf_pkg::POS_MIN_TCP) ||
            (proto_q == sipf_pkg::PROTO_UDP && pos_q < sipf_pkg::POS_MIN_UDP)) begin
          verdict.reason = sipf_pkg::REASON_NOT_IP;
        end else begin
          verdict.src_port = sport_q;
          verdict.reason   = (|pt_hit_q) ? sipf_pkg::REASON_BLK_PORT
                                         : sipf_pkg::REASON_CLEAN;
        end
      end
    end
    verdict.drop = (verdict.reason == sipf_pkg::REASON_BLK_IP) ||
                   (verdict.reason == sipf_pkg::REASON_BLK_PORT);
  end

  // Frame capture, sweeps and table bookkeeping
  always_comb begin
    pos_d     = pos_q;
    etype_d   = etype_q;
    proto_d   = proto_q;
    sip_d     = sip_q;
    sport_d   = sport_q;
    ip_vld_d  = ip_vld_q;
    ip_hit_d  = ip_hit_q;
    ip_arm_d  = ip_arm_q;
    ip_act_d  = ip_act_q;
    ip_idx_d  = ip_idx_q;
    ip_pend_d = ip_act_q;
    ip_ridx_d = ip_idx_q;
    ip_skip_d = 1'b0;
    pt_vld_d  = pt_vld_q;
    pt_hit_d  = pt_hit_q;
    pt_arm_d  = pt_arm_q;
    pt_act_d  = pt_act_q;
    pt_idx_d  = pt_idx_q;
    pt_pend_d = pt_act_q;
    pt_ridx_d = pt_idx_q;
    pt_skip_d = 1'b0;

    // sweep step: issue the next read
    if (ip_act_q) begin
      ip_idx_d = ip_idx_q + IP_AW'(1);
      if (ip_idx_q == IP_AW'(IP_ENTRIES - 1)) ip_act_d = 1'b0;
    end
    if (pt_act_q) begin
      pt_idx_d = pt_idx_q + PORT_AW'(1);
      if (pt_idx_q == PORT_AW'(PORT_ENTRIES - 1)) pt_act_d = 1'b0;
    end

    // sweep step: compare returned entry, unless written as it was read
    if (ip_pend_q && !ip_skip_q) begin
      ip_hit_d[ip_ridx_q] = ip_vld_q[ip_ridx_q] && (ip_rdata == sip_q);
    end
    if (pt_pend_q && !pt_skip_q) begin
      pt_hit_d[pt_ridx_q] = pt_vld_q[pt_ridx_q] && (pt_rdata == sport_q);
    end

    if (in_acc) begin
      // table writes: valid flag, and direct match once the key is known
      if (ip_wr) begin
        ip_vld_d[ip_widx] = in_valid_bit;
        if (ip_arm_q) ip_hit_d[ip_widx] = in_valid_bit && (in_value == sip_q);
        ip_skip_d = ip_act_q && (ip_idx_q == ip_widx);
      end
      if (port_wr) begin
        pt_vld_d[port_widx] = in_valid_bit;
        if (pt_arm_q) pt_hit_d[port_widx] = in_valid_bit && (in_value[15:0] == sport_q);
        pt_skip_d = pt_act_q && (pt_idx_q == port_widx);
      end

      if (frame_beat) begin
        // header capture
        if (pos_q == sipf_pkg::POS_ETYPE_HI || pos_q == sipf_pkg::POS_ETYPE_LO) begin
          etype_d = {etype_q[7:0], in_byte};
        end else if (pos_q == sipf_pkg::POS_PROTO) begin
          proto_d = in_byte;
        end else if (pos_q inside {[sipf_pkg::POS_SIP_FIRST:sipf_pkg::POS_SIP_LAST]}) begin
          sip_d = {sip_q[23:0], in_byte};
        end else if (pos_q == sipf_pkg::POS_SPORT_HI || pos_q == sipf_pkg::POS_SPORT_LO) begin
          sport_d = {sport_q[7:0], in_byte};
        end
        if (pos_q != sipf_pkg::POS_MAX) pos_d = pos_q + 6'd1;

        if (s_axis_tlast) begin
          // verdict taken: back to an empty frame
          pos_d    = '0;
          etype_d  = '0;
          proto_d  = '0;
          sip_d    = '0;
          sport_d  = '0;
          ip_arm_d = 1'b0;
          pt_arm_d = 1'b0;
          ip_hit_d = '0;
          pt_hit_d = '0;
        end else begin
          // key complete: start the sweep over the table
          if (pos_q == sipf_pkg::POS_SIP_LAST) begin
            ip_arm_d = 1'b1;
            ip_act_d = 1'b1;
            ip_idx_d = '0;
          end
          if (pos_q == sipf_pkg::POS_SPORT_LO) begin
            pt_arm_d = 1'b1;
            pt_act_d = 1'b1;
            pt_idx_d = '0;
          end
        end
      end
    end
  end

  // Output register
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_axis_tready) m_valid_d = 1'b0;
    if (in_acc && verdict_req) begin
      m_valid_d = 1'b1;
      m_data_d  = verdict;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_data_q};

  // Control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      etype_q   <= '0;
      proto_q   <= '0;
      sip_q     <= '0;
      sport_q   <= '0;
      ip_vld_q  <= '0;
      ip_hit_q  <= '0;
      ip_arm_q  <= 1'b0;
      ip_act_q  <= 1'b0;
      ip_idx_q  <= '0;
      ip_pend_q <= 1'b0;
      ip_ridx_q <= '0;
      ip_skip_q <= 1'b0;
      pt_vld_q  <= '0;
      pt_hit_q  <= '0;
      pt_arm_q  <= 1'b0;
      pt_act_q  <= 1'b0;
      pt_idx_q  <= '0;
      pt_pend_q <= 1'b0;
      pt_ridx_q <= '0;
      pt_skip_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      etype_q   <= etype_d;
      proto_q   <= proto_d;
      sip_q     <= sip_d;
      sport_q   <= sport_d;
      ip_vld_q  <= ip_vld_d;
      ip_hit_q  <= ip_hit_d;
      ip_arm_q  <= ip_arm_d;
      ip_act_q  <= ip_act_d;
      ip_idx_q  <= ip_idx_d;
      ip_pend_q <= ip_pend_d;
      ip_ridx_q <= ip_ridx_d;
      ip_skip_q <= ip_skip_d;
      pt_vld_q  <= pt_vld_d;
      pt_hit_q  <= pt_hit_d;
      pt_arm_q  <= pt_arm_d;
      pt_act_q  <= pt_act_d;
      pt_idx_q  <= pt_idx_d;
      pt_pend_q <= pt_pend_d;
      pt_ridx_q <= pt_ridx_d;
      pt_skip_q <= pt_skip_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Verdict payload
  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  // A verdict is never taken while a sweep is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && verdict_req) |-> !sweep_busy)
    else $error("verdict taken during table sweep");

  // A sweep only runs for a frame whose key is complete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ip_act_q || ip_pend_q) |-> ip_arm_q)
    else $error("IP sweep without captured address");

  // The port key only completes after the address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_arm_q |-> ip_arm_q)
    else $error("port armed without address");

  // The IP sweep starts right after the last address byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ip_arm_q) |-> ($past(pos_q) == sipf_pkg::POS_SIP_LAST && pos_q == 6'd30))
    else $error("IP sweep started at wrong byte");

endmodule

FILE: sv/sipf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module sipf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
